// ===== rtl/lmph_pkg.sv =====
// Shared types and constants for the bar-graph level meter with peak hold.
// Used by the channel interfaces and the top level; the divider does not use it.
package lmph_pkg;

  localparam int LVL_W      = 16;
  localparam int COEF_W     = 16;
  localparam int HOLD_W     = 8;
  localparam int OP_W       = 2;
  localparam int LIT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [LVL_W-1:0] FLOOR_RST = -16'sd15360;
  localparam logic signed [LVL_W-1:0] CEIL_RST  = 16'sd0;
  localparam logic [COEF_W-1:0]       RISE_RST  = 16'd39322;
  localparam logic [COEF_W-1:0]       FALL_RST  = 16'd6554;
  localparam logic [HOLD_W-1:0]       HOLD_RST  = 8'd30;

  localparam logic [COEF_W-1:0]     PEAK_DECAY   = 16'd5243;
  localparam logic signed [LVL_W:0] SNAP_LSB     = 17'sd2;
  localparam logic signed [LVL_W:0] FLOOR_MARGIN = 17'sd128;

  typedef enum logic [OP_W-1:0] {
    OP_LEVEL    = 2'd0,
    OP_TICK     = 2'd1,
    OP_SET_PEAK = 2'd2,
    OP_CLR_PEAK = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR = 3'd0,
    CFG_CEIL  = 3'd1,
    CFG_RISE  = 3'd2,
    CFG_FALL  = 3'd3,
    CFG_HOLD  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_SAPPLY,
    ST_PEAK,
    ST_PMUL,
    ST_PAPPLY,
    ST_SEG,
    ST_NMUL,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/lmph_in_if.sv =====
// Input channel of the level meter: valid/ready handshake with op and level.
// Depends on lmph_pkg for field widths.
interface lmph_in_if import lmph_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [LVL_W-1:0] level_db;

  modport source (output valid, op, level_db, input ready);
  modport sink   (input valid, op, level_db, output ready);
endinterface

// ===== rtl/lmph_out_if.sv =====
// Result channel of the level meter: valid/ready handshake with meter readings.
// Depends on lmph_pkg for field widths.
interface lmph_out_if import lmph_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [LIT_W-1:0]        lit_segments;
  logic signed [LVL_W-1:0] shown_db;
  logic signed [LVL_W-1:0] held_peak_db;
  logic                    at_floor;

  modport source (output valid, lit_segments, shown_db, held_peak_db, at_floor, input ready);
  modport sink   (input valid, lit_segments, shown_db, held_peak_db, at_floor, output ready);
endinterface

// ===== rtl/lmph_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Standalone; the quotient must fit in QUO_W bits.
module lmph_div #(
  parameter int QUO_W = 5,
  parameter int NUM_W = 34,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  assign ge = rem_r >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (QUO_W - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_r - dsh_r : rem_r;
      dsh_nxt = dsh_r >> 1;
      q_nxt   = {q_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/bargraph_level_meter_peak_hold.sv =====
// Bar-graph level meter with rise/fall ballistics and peak hold.
// A refresh tick updates the shown level and then the held peak; each word then gets its
// segment count, by division unless the bar is empty or full, and its result word is
// registered. One shared multiplier and a one-bit-per-cycle divider serve these steps; the
// next word is accepted only once a result is registered. Synchronous active-low reset loads
// the defaults and floors all levels.
module bargraph_level_meter_peak_hold import lmph_pkg::*; #(
  parameter int SEGMENTS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lmph_in_if.sink               in_ch,
  lmph_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QUO_W  = $clog2(SEGMENTS + 1);
  localparam int PROD_W = LVL_W + 1 + COEF_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = LVL_W + 2;
  localparam logic [COEF_W-1:0] SEG2     = COEF_W'(2 * SEGMENTS);
  localparam logic [QUO_W-1:0]  SEG_FULL = QUO_W'(SEGMENTS);

  state_t state_r, state_nxt;

  logic signed [LVL_W-1:0] floor_r, floor_nxt;
  logic signed [LVL_W-1:0] ceil_r, ceil_nxt;
  logic [COEF_W-1:0]       rise_r, rise_nxt;
  logic [COEF_W-1:0]       fall_r, fall_nxt;
  logic [HOLD_W-1:0]       hticks_r, hticks_nxt;
  logic signed [LVL_W-1:0] target_r, target_nxt;
  logic signed [LVL_W-1:0] shown_r, shown_nxt;
  logic signed [LVL_W-1:0] peak_r, peak_nxt;
  logic [HOLD_W-1:0]       hold_r, hold_nxt;
  logic [LVL_W:0]          mag_r, mag_nxt;
  logic [COEF_W-1:0]       coef_r, coef_nxt;
  logic                    dir_r, dir_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [QUO_W-1:0]        seg_r, seg_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [LIT_W-1:0]        out_lit_r, out_lit_nxt;
  logic signed [LVL_W-1:0] out_shown_r, out_shown_nxt;
  logic signed [LVL_W-1:0] out_peak_r, out_peak_nxt;
  logic                    out_floor_r, out_floor_nxt;

  logic                    accept;
  logic                    out_load;
  logic                    div_start;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;

  logic signed [LVL_W-1:0] lvl_c;
  logic signed [LVL_W-1:0] new_floor, new_ceil;
  logic signed [LVL_W:0]   tgt_x, shn_x, pk_x, flr_x, cl_x;
  logic signed [LVL_W:0]   tick_diff, sh_new, snap_d, pk_new, seg_num, seg_den;
  logic                    tick_up, snap, peak_above, hold_nz, seg_zero, seg_full;
  logic [PROD_W-1:0]       mul_p;
  logic [PROD_W:0]         rnd;
  logic [LVL_W:0]          step;

  function automatic logic signed [LVL_W-1:0] clamp_lvl(
    input logic signed [LVL_W-1:0] v,
    input logic signed [LVL_W-1:0] lo,
    input logic signed [LVL_W-1:0] hi
  );
    logic signed [LVL_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign lvl_c = clamp_lvl(in_ch.level_db, floor_r, ceil_r);

  assign tgt_x = {target_r[LVL_W-1], target_r};
  assign shn_x = {shown_r[LVL_W-1], shown_r};
  assign pk_x  = {peak_r[LVL_W-1], peak_r};
  assign flr_x = {floor_r[LVL_W-1], floor_r};
  assign cl_x  = {ceil_r[LVL_W-1], ceil_r};

  assign tick_up   = target_r > shown_r;
  assign tick_diff = tgt_x - shn_x;

  // Shared multiplier and rounding: step = ceil(mag * coef / 2^16).
  assign mul_p = PROD_W'(mag_r) * PROD_W'(coef_r);
  assign rnd   = {1'b0, prod_r} + (PROD_W + 1)'(17'h0FFFF);
  assign step  = rnd[COEF_W+LVL_W:COEF_W];

  assign sh_new = dir_r ? shn_x + $signed(step) : shn_x - $signed(step);
  assign snap_d = sh_new - tgt_x;
  assign snap   = (snap_d >= -SNAP_LSB) && (snap_d <= SNAP_LSB);
  assign pk_new = pk_x - $signed(step);

  assign peak_above = peak_r > shown_r;
  assign hold_nz    = hold_r != '0;

  assign seg_num  = shn_x - flr_x;
  assign seg_den  = cl_x - flr_x;
  assign seg_zero = !(ceil_r > floor_r) || (seg_num <= 0);
  assign seg_full = seg_num >= seg_den;

  assign div_num = NUM_W'(prod_r) + NUM_W'(seg_den[LVL_W:0]);
  assign div_den = {seg_den[LVL_W:0], 1'b0};

  assign new_floor = (cfg_index == CFG_FLOOR) ? $signed(cfg_wdata) : floor_r;
  assign new_ceil  = (cfg_index == CFG_CEIL) ? $signed(cfg_wdata) : ceil_r;

  lmph_div #(
    .QUO_W (QUO_W),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_DSTART: div_start = 1'b1;
      ST_OUT:    out_load = !out_valid_r || out_ch.ready;
      default:   ;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (op_t'(in_ch.op) == OP_TICK) ? ST_SMUL : ST_SEG;
        end
      end
      ST_SMUL:   state_nxt = ST_SAPPLY;
      ST_SAPPLY: state_nxt = ST_PEAK;
      ST_PEAK: begin
        state_nxt = (!hold_nz && peak_above) ? ST_PMUL : ST_SEG;
      end
      ST_PMUL:   state_nxt = ST_PAPPLY;
      ST_PAPPLY: state_nxt = ST_SEG;
      ST_SEG: begin
        state_nxt = (seg_zero || seg_full) ? ST_OUT : ST_NMUL;
      end
      ST_NMUL:   state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    floor_nxt  = floor_r;
    ceil_nxt   = ceil_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    hticks_nxt = hticks_r;
    target_nxt = target_r;
    shown_nxt  = shown_r;
    peak_nxt   = peak_r;
    hold_nxt   = hold_r;
    mag_nxt    = mag_r;
    coef_nxt   = coef_r;
    dir_nxt    = dir_r;
    prod_nxt   = prod_r;
    seg_nxt    = seg_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_ch.op))
            OP_LEVEL: begin
              target_nxt = lvl_c;
              if (lvl_c > peak_r) begin
                peak_nxt = lvl_c;
                hold_nxt = hticks_r;
              end
            end
            OP_TICK: begin
              mag_nxt  = tick_up ? $unsigned(tick_diff) : $unsigned(-tick_diff);
              coef_nxt = tick_up ? rise_r : fall_r;
              dir_nxt  = tick_up;
            end
            OP_SET_PEAK: begin
              peak_nxt = lvl_c;
              hold_nxt = hticks_r;
            end
            OP_CLR_PEAK: begin
              peak_nxt = floor_r;
              hold_nxt = '0;
            end
            default: ;
          endcase
        end else if (cfg_we) begin
          case (cfg_index)
            CFG_FLOOR, CFG_CEIL: begin
              floor_nxt  = new_floor;
              ceil_nxt   = new_ceil;
              target_nxt = clamp_lvl(target_r, new_floor, new_ceil);
              shown_nxt  = clamp_lvl(shown_r, new_floor, new_ceil);
              peak_nxt   = clamp_lvl(peak_r, new_floor, new_ceil);
            end
            CFG_RISE: rise_nxt   = cfg_wdata;
            CFG_FALL: fall_nxt   = cfg_wdata;
            CFG_HOLD: hticks_nxt = cfg_wdata[HOLD_W-1:0];
            default:  ;
          endcase
        end
      end
      ST_SMUL, ST_PMUL, ST_NMUL: prod_nxt = mul_p;
      ST_SAPPLY: shown_nxt = snap ? target_r : sh_new[LVL_W-1:0];
      ST_PEAK: begin
        if (hold_nz) begin
          hold_nxt = hold_r - 1'b1;
        end else if (peak_above) begin
          mag_nxt  = $unsigned(pk_x - shn_x);
          coef_nxt = PEAK_DECAY;
        end else begin
          peak_nxt = shown_r;
        end
      end
      ST_PAPPLY: peak_nxt = pk_new[LVL_W-1:0];
      ST_SEG: begin
        if (seg_zero) begin
          seg_nxt = '0;
        end else if (seg_full) begin
          seg_nxt = SEG_FULL;
        end else begin
          mag_nxt  = $unsigned(seg_num);
          coef_nxt = SEG2;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          seg_nxt = div_quo;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_lit_nxt   = out_lit_r;
    out_shown_nxt = out_shown_r;
    out_peak_nxt  = out_peak_r;
    out_floor_nxt = out_floor_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_lit_nxt   = LIT_W'(seg_r);
      out_shown_nxt = shown_r;
      out_peak_nxt  = peak_r;
      out_floor_nxt = shn_x <= flr_x + FLOOR_MARGIN;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      floor_r     <= FLOOR_RST;
      ceil_r      <= CEIL_RST;
      rise_r      <= RISE_RST;
      fall_r      <= FALL_RST;
      hticks_r    <= HOLD_RST;
      target_r    <= FLOOR_RST;
      shown_r     <= FLOOR_RST;
      peak_r      <= FLOOR_RST;
      hold_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      floor_r     <= floor_nxt;
      ceil_r      <= ceil_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      hticks_r    <= hticks_nxt;
      target_r    <= target_nxt;
      shown_r     <= shown_nxt;
      peak_r      <= peak_nxt;
      hold_r      <= hold_nxt;
    end
    mag_r       <= mag_nxt;
    coef_r      <= coef_nxt;
    dir_r       <= dir_nxt;
    prod_r      <= prod_nxt;
    seg_r       <= seg_nxt;
    out_lit_r   <= out_lit_nxt;
    out_shown_r <= out_shown_nxt;
    out_peak_r  <= out_peak_nxt;
    out_floor_r <= out_floor_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.lit_segments = out_lit_r;
  assign out_ch.shown_db     = out_shown_r;
  assign out_ch.held_peak_db = out_peak_r;
  assign out_ch.at_floor     = out_floor_r;

  // The displayed level never leaves a valid meter range.
  a_shown_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ceil_r > floor_r) |-> (shown_r >= floor_r && shown_r <= ceil_r))
    else $error("displayed level outside meter range");

  // A result word never reports more segments than the bar has.
  a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (SEGMENTS > 31 || out_ch.lit_segments <= LIT_W'(SEGMENTS)))
    else $error("segment count above bar length");

  // An accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("new word accepted while previous one still in work");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DWAIT)
    else $error("divider completion outside wait state");

endmodule

// ===== verif/bargraph_level_meter_peak_hold_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bar-graph level meter: predicts every result word and compares it.
// Depends on lmph_pkg and the lmph_in_if / lmph_out_if channel interfaces.
module bargraph_level_meter_peak_hold_checker import lmph_pkg::*; #(
  parameter int SEGMENTS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lmph_in_if                    in_ch,
  lmph_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [LIT_W-1:0]        lit;
    logic signed [LVL_W-1:0] shown;
    logic signed [LVL_W-1:0] peak;
    logic                    at_floor;
  } meter_word_t;

  meter_word_t readings_due[$];
  int misses = 0;

  int floor_lvl, ceil_lvl, rise_k, fall_k, hold_len;
  int target_lvl, shown_lvl, peak_lvl, hold_left;

  function automatic int clamp_lvl(int v);
    if (v < floor_lvl) return floor_lvl;
    if (v > ceil_lvl) return ceil_lvl;
    return v;
  endfunction

  function automatic int glide(int from, int to, int k);
    int diff;
    longint mag, stp;
    diff = to - from;
    mag  = (diff < 0) ? -longint'(diff) : longint'(diff);
    stp  = (mag * longint'(k) + 65535) >>> 16;
    return (diff < 0) ? from - int'(stp) : from + int'(stp);
  endfunction

  function automatic logic [LIT_W-1:0] bar_count();
    longint num, den, n;
    if (ceil_lvl <= floor_lvl) return '0;
    num = longint'(shown_lvl) - longint'(floor_lvl);
    den = longint'(ceil_lvl) - longint'(floor_lvl);
    if (num <= 0) return '0;
    n = (num * 2 * SEGMENTS + den) / (2 * den);
    if (n > SEGMENTS) n = SEGMENTS;
    return n[LIT_W-1:0];
  endfunction

  task automatic load_defaults();
    floor_lvl  = int'(FLOOR_RST);
    ceil_lvl   = int'(CEIL_RST);
    rise_k     = int'(RISE_RST);
    fall_k     = int'(FALL_RST);
    hold_len   = int'(HOLD_RST);
    target_lvl = floor_lvl;
    shown_lvl  = floor_lvl;
    peak_lvl   = floor_lvl;
    hold_left  = 0;
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (cfg_idx_t'(idx))
      CFG_FLOOR, CFG_CEIL: begin
        if (cfg_idx_t'(idx) == CFG_FLOOR) floor_lvl = int'($signed(val[LVL_W-1:0]));
        else ceil_lvl = int'($signed(val[LVL_W-1:0]));
        target_lvl = clamp_lvl(target_lvl);
        shown_lvl  = clamp_lvl(shown_lvl);
        peak_lvl   = clamp_lvl(peak_lvl);
      end
      CFG_RISE: rise_k = int'(val[COEF_W-1:0]);
      CFG_FALL: fall_k = int'(val[COEF_W-1:0]);
      CFG_HOLD: hold_len = int'(val[HOLD_W-1:0]);
      default: ;
    endcase
  endtask

  function automatic meter_word_t step_meter(logic [OP_W-1:0] op,
                                             logic signed [LVL_W-1:0] lvl_in);
    meter_word_t w;
    int lvl, k, gap;
    lvl = clamp_lvl(int'(lvl_in));
    case (op_t'(op))
      OP_LEVEL: begin
        target_lvl = lvl;
        if (lvl > peak_lvl) begin
          peak_lvl  = lvl;
          hold_left = hold_len;
        end
      end
      OP_TICK: begin
        k = (target_lvl > shown_lvl) ? rise_k : fall_k;
        shown_lvl = glide(shown_lvl, target_lvl, k);
        gap = shown_lvl - target_lvl;
        if (gap >= -int'(SNAP_LSB) && gap <= int'(SNAP_LSB)) shown_lvl = target_lvl;
        if (hold_left > 0) begin
          hold_left--;
        end else if (peak_lvl > shown_lvl) begin
          peak_lvl = glide(peak_lvl, shown_lvl, int'(PEAK_DECAY));
        end else begin
          peak_lvl = shown_lvl;
        end
      end
      OP_SET_PEAK: begin
        peak_lvl  = lvl;
        hold_left = hold_len;
      end
      default: begin
        peak_lvl  = floor_lvl;
        hold_left = 0;
      end
    endcase
    w.lit      = bar_count();
    w.shown    = shown_lvl[LVL_W-1:0];
    w.peak     = peak_lvl[LVL_W-1:0];
    w.at_floor = (shown_lvl <= floor_lvl + int'(FLOOR_MARGIN));
    return w;
  endfunction

  task automatic note_miss(string msg);
    misses++;
    if (misses <= 10) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk) begin
    meter_word_t want;
    if (!rst_n) begin
      load_defaults();
      readings_due.delete();
    end else begin
      if (cfg_we) write_setting(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        readings_due.push_back(step_meter(in_ch.op, in_ch.level_db));
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          note_miss($sformatf("result word with none expected: shown_db %0d",
                              out_ch.shown_db));
        end else begin
          want = readings_due.pop_front();
          if (out_ch.lit_segments !== want.lit)
            note_miss($sformatf("lit_segments: expected %0d, got %0d",
                                want.lit, out_ch.lit_segments));
          if (out_ch.shown_db !== want.shown)
            note_miss($sformatf("shown_db: expected %0d, got %0d",
                                want.shown, out_ch.shown_db));
          if (out_ch.held_peak_db !== want.peak)
            note_miss($sformatf("held_peak_db: expected %0d, got %0d",
                                want.peak, out_ch.held_peak_db));
          if (out_ch.at_floor !== want.at_floor)
            note_miss($sformatf("at_floor: expected %0b, got %0b",
                                want.at_floor, out_ch.at_floor));
        end
      end
    end
    pending    <= readings_due.size();
    fail_count <= misses;
  end

endmodule

// ===== verif/bargraph_level_meter_peak_hold_tb.sv =====
`timescale 1ns / 1ps
// Top of the level meter testbench: clock, reset, register writes and word traffic.
// Depends on lmph_pkg, the channel interfaces, the block and its checker module.
module bargraph_level_meter_peak_hold_tb;
  import lmph_pkg::*;

  localparam int SEGMENTS      = 24;
  localparam int RX_HOLD_OFF   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;
  int                    tx_busy_pct = 30;
  int                    rx_busy_pct = 30;
  int                    span_lo = -15360;
  int                    span_hi = 0;
  bit                    rx_hold_req = 1'b0;

  lmph_in_if  in_ch();
  lmph_out_if out_ch();

  bargraph_level_meter_peak_hold #(.SEGMENTS(SEGMENTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bargraph_level_meter_peak_hold_checker #(.SEGMENTS(SEGMENTS)) meter_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [LVL_W-1:0] pick_level();
    int lo, hi, v;
    logic [LVL_W-1:0] raw;
    raw = LVL_W'($urandom);
    lo  = (span_lo < span_hi) ? span_lo : span_hi;
    hi  = (span_lo < span_hi) ? span_hi : span_lo;
    case ($urandom_range(0, 9))
      0, 1: return raw;
      2: v = lo + int'($urandom_range(0, 4)) - 2;
      3: v = hi + int'($urandom_range(0, 4)) - 2;
      default: v = lo - 256 + int'($urandom_range(0, hi - lo + 512));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[LVL_W-1:0];
  endfunction

  function automatic logic signed [LVL_W-1:0] any_level();
    logic [LVL_W-1:0] raw;
    raw = LVL_W'($urandom);
    return raw;
  endfunction

  // Offers one word, waits for it to be taken, then maybe idles the channel.
  task automatic feed(op_t op, logic signed [LVL_W-1:0] lvl);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.level_db <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = pick_gap(tx_busy_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      feed(OP_LEVEL, pick_level());
    end else if (r < 80) begin
      feed(OP_TICK, any_level());
    end else if (r < 88) begin
      n = $urandom_range(8, 40);
      repeat (n) feed(OP_TICK, any_level());
    end else if (r < 95) begin
      feed(OP_SET_PEAK, pick_level());
    end else begin
      feed(OP_CLR_PEAK, any_level());
    end
  endtask

  task automatic run_phase(int fl, int ce, int rise, int fall, int hold, int items,
                           int tx_pct, int rx_pct);
    drain();
    write_reg(CFG_FLOOR, CFG_DATA_W'(fl));
    write_reg(CFG_CEIL, CFG_DATA_W'(ce));
    write_reg(CFG_RISE, CFG_DATA_W'(rise));
    write_reg(CFG_FALL, CFG_DATA_W'(fall));
    write_reg(CFG_HOLD, CFG_DATA_W'(hold));
    span_lo     = fl;
    span_hi     = ce;
    tx_busy_pct = tx_pct;
    rx_busy_pct = rx_pct;
    repeat (items) random_item();
  endtask

  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_OFF) @(posedge clk);
        held = 1'b1;
      end else begin
        gap = pick_gap(rx_busy_pct);
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bargraph_level_meter_peak_hold: mismatch");
      $finish;
    end
  end

  initial begin
    int fl, ce;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FLOOR;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_LEVEL;
    in_ch.level_db <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed run at the reset range: clamping, rise and fall, peak handling.
    feed(OP_LEVEL, 16'sd0);
    repeat (3) feed(OP_TICK, 16'sd0);
    feed(OP_LEVEL, 16'sd32767);
    feed(OP_TICK, -16'sd1);
    feed(OP_LEVEL, -16'sd32768);
    repeat (2) feed(OP_TICK, 16'sd32767);
    feed(OP_SET_PEAK, 16'sd32767);
    feed(OP_SET_PEAK, -16'sd32768);
    feed(OP_CLR_PEAK, 16'sd32767);
    feed(OP_CLR_PEAK, -16'sd32768);
    feed(OP_LEVEL, -16'sd7680);
    repeat (3) feed(OP_TICK, -16'sd21846);
    feed(OP_LEVEL, -16'sd15300);
    repeat (2) feed(OP_TICK, 16'sd21845);
    feed(OP_LEVEL, -16'sd15359);
    repeat (2) feed(OP_TICK, 16'sd0);

    run_phase(-15360, 0, 39322, 6554, 30, 45, 30, 30);

    // Receiver holds off while the sender keeps offering words back to back.
    tx_busy_pct = 0;
    rx_hold_req = 1'b1;
    repeat (15) random_item();
    drain();
    tx_busy_pct = 20;
    repeat (10) random_item();

    run_phase(-32768, 32767, 65535, 65535, 0, 45, 0, 0);
    run_phase(-15360, 0, 0, 1, 255, 35, 40, 20);
    run_phase(2560, -2560, 30000, 9000, 5, 35, 20, 40);
    run_phase(-1280, -1280, 20000, 20000, 2, 20, 10, 10);
    run_phase(-100, 140, 65535, 20000, 3, 30, 25, 25);
    repeat (5) begin
      fl = -20000 + int'($urandom_range(0, 18000));
      ce = fl + int'($urandom_range(256, 20000));
      run_phase(fl, ce, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 40), 30, $urandom_range(0, 50), $urandom_range(0, 50));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bargraph_level_meter_peak_hold: match");
    end else begin
      $display("bargraph_level_meter_peak_hold: mismatch");
    end
    $finish;
  end

endmodule
